[rtl/ess_pkg.sv]
// ============================================================================
// ess_pkg - shared types and constants for the elevator SCAN scheduler
// Operation codes, motion codes, field widths and the result word layout.
// ============================================================================
`default_nettype none

package ess_pkg;

    localparam int FUNC_W  = 3;
    localparam int FLOOR_W = 6;
    localparam int STAT_W  = 2;
    localparam int COST_W  = 7;

    localparam int MAX_FLOORS_DEFAULT = 63;

    // operation codes
    localparam logic [FUNC_W-1:0] FN_TICK    = 3'd0;
    localparam logic [FUNC_W-1:0] FN_REQUEST = 3'd1;
    localparam logic [FUNC_W-1:0] FN_COST    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_ENABLE  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISABLE = 3'd4;

    // motion / status codes
    localparam logic [STAT_W-1:0] MOT_WAIT = 2'd0;
    localparam logic [STAT_W-1:0] MOT_UP   = 2'd1;
    localparam logic [STAT_W-1:0] MOT_DOWN = 2'd2;
    localparam logic [STAT_W-1:0] MOT_OFF  = 2'd3;

    localparam logic [COST_W-1:0] COST_MAX = 7'd126;

    typedef struct packed {
        logic                serviced;
        logic [FLOOR_W-1:0]  position;
        logic [STAT_W-1:0]   status;
        logic [COST_W-1:0]   cost;
        logic                rejected;
    } ess_result_t;

endpackage

`default_nettype wire

[rtl/ess_if.sv]
// ============================================================================
// ess_if - channel interfaces of the elevator SCAN scheduler
// Item input channel, result output channel and configuration write channel.
// ============================================================================
`default_nettype none

interface ess_in_if import ess_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FUNC_W-1:0]  func;
    logic [FLOOR_W-1:0] floor;

    modport source (output valid, output func, output floor, input ready);
    modport sink   (input valid, input func, input floor, output ready);
endinterface

interface ess_out_if import ess_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               serviced;
    logic [FLOOR_W-1:0] position;
    logic [STAT_W-1:0]  status;
    logic [COST_W-1:0]  cost;
    logic               rejected;

    modport source (output valid, output serviced, output position, output status,
                    output cost, output rejected, input ready);
    modport sink   (input valid, input serviced, input position, input status,
                    input cost, input rejected, output ready);
endinterface

interface ess_cfg_if import ess_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [FLOOR_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ess_step.sv]
// ============================================================================
// ess_step - next-state logic of the elevator SCAN scheduler
// Applies one word to the car state and forms its result, all combinational.
// ============================================================================
`default_nettype none

module ess_step import ess_pkg::*; #(
    parameter int PW    = 64,
    parameter int IDX_W = 6,
    parameter int NF_W  = 6
) (
    input  wire logic [FUNC_W-1:0]  func,
    input  wire logic [FLOOR_W-1:0] floor,
    input  wire logic [NF_W-1:0]    num_floors,
    input  wire logic [FLOOR_W-1:0] car,
    input  wire logic [STAT_W-1:0]  motion,
    input  wire logic               active,
    input  wire logic [PW-1:0]      above,
    input  wire logic [PW-1:0]      below,
    output logic      [FLOOR_W-1:0] car_nxt,
    output logic      [STAT_W-1:0]  motion_nxt,
    output logic                    active_nxt,
    output logic      [PW-1:0]      above_nxt,
    output logic      [PW-1:0]      below_nxt,
    output ess_result_t             res
);

    // compare width wide enough for floor+1 and for num_floors
    localparam int CMP_W = (NF_W > FLOOR_W + 1) ? NF_W : FLOOR_W + 1;

    function automatic logic [STAT_W-1:0] refresh(
        input logic [STAT_W-1:0] m,
        input logic              a_nz,
        input logic              b_nz
    );
        logic [STAT_W-1:0] r;
        r = m;
        if (!a_nz && !b_nz)
            r = MOT_WAIT;
        else if (m == MOT_WAIT)
            r = a_nz ? MOT_UP : MOT_DOWN;
        else if (!((m == MOT_UP) ? a_nz : b_nz))
            r = (m == MOT_DOWN) ? MOT_UP : MOT_DOWN;
        return r;
    endfunction

    logic [IDX_W-1:0]   lo_idx;
    logic [IDX_W-1:0]   hi_idx;
    logic [IDX_W-1:0]   target;
    logic [STAT_W-1:0]  m1;
    logic [STAT_W-1:0]  m2;
    logic               hit;
    logic [PW-1:0]      clr_mask;
    logic [PW-1:0]      above_clr;
    logic [PW-1:0]      below_clr;
    logic [CMP_W-1:0]   p_raw;
    logic [CMP_W-1:0]   p_clamp;
    logic [CMP_W-1:0]   nf_ext;
    logic [CMP_W-1:0]   floor_ext;
    logic [COST_W-1:0]  cnt_above;
    logic [COST_W-1:0]  cnt_below;
    logic [FLOOR_W-1:0] span;
    logic [COST_W:0]    cost_sum;
    logic               flr_bad;

    // lowest pending above, highest pending below
    always_comb
    begin
        lo_idx = '0;
        hi_idx = '0;
        for (int i = PW - 1; i >= 0; i--)
        begin
            if (above[i])
                lo_idx = IDX_W'(i);
        end
        for (int i = 0; i < PW; i++)
        begin
            if (below[i])
                hi_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        cnt_above = '0;
        cnt_below = '0;
        for (int i = 0; i < PW; i++)
        begin
            cnt_above = cnt_above + COST_W'(above[i]);
            cnt_below = cnt_below + COST_W'(below[i]);
        end
    end

    assign nf_ext    = CMP_W'(num_floors);
    assign floor_ext = CMP_W'(floor);
    assign flr_bad   = floor_ext > nf_ext;

    // tick path: refresh, service, refresh again, move
    assign m1        = refresh(motion, |above, |below);
    assign target    = (m1 == MOT_UP) ? lo_idx : hi_idx;
    assign hit       = (FLOOR_W'(target) == car);
    assign clr_mask  = ~(PW'(1) << target);
    assign above_clr = (m1 == MOT_UP) ? (above & clr_mask) : above;
    assign below_clr = (m1 == MOT_UP) ? below : (below & clr_mask);
    assign m2        = hit ? refresh(m1, |above_clr, |below_clr) : m1;

    always_comb
    begin
        if (m2 == MOT_UP)
            p_raw = CMP_W'(car) + CMP_W'(1);
        else if (car == '0)
            p_raw = '0;
        else
            p_raw = CMP_W'(car) - CMP_W'(1);
        p_clamp = (p_raw > nf_ext) ? nf_ext : p_raw;
    end

    assign span     = (floor > car) ? (floor - car) : (car - floor);
    assign cost_sum = (COST_W + 1)'(span) +
                      (COST_W + 1)'((floor > car) ? cnt_above : cnt_below);

    always_comb
    begin
        car_nxt    = car;
        motion_nxt = motion;
        active_nxt = active;
        above_nxt  = above;
        below_nxt  = below;
        res        = '0;
        unique case (func)
            FN_TICK:
            begin
                if (active)
                begin
                    if (m1 == MOT_WAIT)
                    begin
                        motion_nxt   = MOT_WAIT;
                        res.serviced = 1'b1;
                    end
                    else
                    begin
                        if (hit)
                        begin
                            above_nxt = above_clr;
                            below_nxt = below_clr;
                        end
                        motion_nxt   = m2;
                        res.serviced = hit;
                        if (m2 != MOT_WAIT)
                            car_nxt = p_clamp[FLOOR_W-1:0];
                    end
                end
            end
            FN_REQUEST:
            begin
                if (flr_bad)
                    res.rejected = 1'b1;
                else if (floor > car)
                    above_nxt[floor[IDX_W-1:0]] = 1'b1;
                else if (floor < car)
                    below_nxt[floor[IDX_W-1:0]] = 1'b1;
            end
            FN_COST:
            begin
                if (flr_bad)
                    res.rejected = 1'b1;
                else if (floor != car)
                    res.cost = (cost_sum > (COST_W + 1)'(COST_MAX)) ? COST_MAX
                                                                     : cost_sum[COST_W-1:0];
            end
            FN_ENABLE:
            begin
                motion_nxt = MOT_WAIT;
                active_nxt = 1'b1;
            end
            FN_DISABLE:
            begin
                motion_nxt = MOT_OFF;
                active_nxt = 1'b0;
            end
            default:
            begin
                // unused codes: no operation
            end
        endcase
        res.position = car_nxt;
        res.status   = motion_nxt;
    end

endmodule

`default_nettype wire

[rtl/elevator_scan_scheduler.sv]
// ============================================================================
// elevator_scan_scheduler - single-car SCAN elevator scheduler
// Tracks car floor, direction and pending floor sets; one result per word.
// ============================================================================
// Usage:
//   item   : input words {func, floor}; tick, request, cost query, enable,
//            disable. Accepted on a clock edge with item.valid && item.ready.
//   result : one output word per item {serviced, position, status, cost,
//            rejected}, held in an output register until result.ready.
//   cfg    : write channel for num_floors, always ready; values above
//            MAX_FLOORS saturate. Write only while the block is idle.
// Result  : valid in the cycle after the item is accepted.
// Throughput: one item per cycle while the output is not stalled. The whole
//   update (priority encoders on the pending sets, popcount, compares) sits
//   between the state and output registers, so the next item can follow it.
// Stall   : item.ready is high when the output register is empty or is being
//   drained in the same cycle; a stalled receiver holds its word and blocks
//   new items until it is taken.
// Reset   : rst_n (async, active low) puts the car at floor 0, waiting and
//   enabled, clears both pending sets, sets num_floors to MAX_FLOORS and
//   empties the output register.
// ============================================================================
`default_nettype none

module elevator_scan_scheduler import ess_pkg::*; #(
    parameter int MAX_FLOORS = MAX_FLOORS_DEFAULT
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ess_in_if.sink     item,
    ess_out_if.source  result,
    ess_cfg_if.sink    cfg
);

    // pending sets only need bits for floors a request can reach
    localparam int PW    = ((MAX_FLOORS < 63) ? MAX_FLOORS : 63) + 1;
    localparam int IDX_W = $clog2(PW);
    localparam int NF_W  = $clog2(MAX_FLOORS + 1);

    logic [NF_W-1:0]    num_floors_reg;
    logic [NF_W-1:0]    num_floors_next;
    logic [FLOOR_W-1:0] car_reg;
    logic [FLOOR_W-1:0] car_next;
    logic [STAT_W-1:0]  motion_reg;
    logic [STAT_W-1:0]  motion_next;
    logic               active_reg;
    logic               active_next;
    logic [PW-1:0]      above_reg;
    logic [PW-1:0]      above_next;
    logic [PW-1:0]      below_reg;
    logic [PW-1:0]      below_next;
    logic               out_valid_reg;
    ess_result_t        out_data_reg;
    ess_result_t        step_res;
    logic               item_fire;

    // output register is free when empty or draining this cycle
    assign item.ready = !out_valid_reg || result.ready;
    assign item_fire  = item.valid && item.ready;
    assign cfg.ready  = 1'b1;

    // register write with saturation to the build-time ceiling
    always_comb
    begin
        if (int'(cfg.data) > MAX_FLOORS)
            num_floors_next = NF_W'(MAX_FLOORS);
        else
            num_floors_next = NF_W'(cfg.data);
    end

    ess_step #(
        .PW    (PW),
        .IDX_W (IDX_W),
        .NF_W  (NF_W)
    ) u_step (
        .func       (item.func),
        .floor      (item.floor),
        .num_floors (num_floors_reg),
        .car        (car_reg),
        .motion     (motion_reg),
        .active     (active_reg),
        .above      (above_reg),
        .below      (below_reg),
        .car_nxt    (car_next),
        .motion_nxt (motion_next),
        .active_nxt (active_next),
        .above_nxt  (above_next),
        .below_nxt  (below_next),
        .res        (step_res)
    );

    // car state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_floors_reg <= NF_W'(MAX_FLOORS);
            car_reg        <= '0;
            motion_reg     <= MOT_WAIT;
            active_reg     <= 1'b1;
            above_reg      <= '0;
            below_reg      <= '0;
        end
        else
        begin
            if (cfg.valid)
                num_floors_reg <= num_floors_next;
            if (item_fire)
            begin
                car_reg    <= car_next;
                motion_reg <= motion_next;
                active_reg <= active_next;
                above_reg  <= above_next;
                below_reg  <= below_next;
            end
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (item_fire)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // output payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (item_fire)
            out_data_reg <= step_res;
    end

    assign result.valid    = out_valid_reg;
    assign result.serviced = out_data_reg.serviced;
    assign result.position = out_data_reg.position;
    assign result.status   = out_data_reg.status;
    assign result.cost     = out_data_reg.cost;
    assign result.rejected = out_data_reg.rejected;

endmodule

`default_nettype wire

[sim/elevator_scan_scheduler_test.sv]
// ----------------------------------------------------------------------------
// elevator_scan_scheduler_test - self-checking bench for the SCAN scheduler
// Drives tick, request, cost, enable, disable and unused words through the
// item channel under random idling and stalls. A scoreboard class keeps its
// own copy of the car state, predicts every result word and checks each
// delivered word field by field. num_floors is rewritten between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module elevator_scan_scheduler_test;
    import ess_pkg::*;

    localparam int unsigned ITEMS_TARGET = 1150;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // ------------------------------------------------------------------------
    // Scoreboard: car state copy, expected result words, field checks
    // ------------------------------------------------------------------------
    class car_route_board;
        logic [FLOOR_W-1:0] top_floor;
        logic [FLOOR_W-1:0] car_floor;
        logic [STAT_W-1:0]  motion;
        bit                 active;
        logic [63:0]        calls_up;     // pending floors above the car
        logic [63:0]        calls_down;   // pending floors below the car
        ess_result_t        due_results[$];
        int unsigned        mismatches;
        int unsigned        checked;
        int unsigned        rejected_seen;
        int unsigned        capped_costs;
        int unsigned        served_ticks;

        function new();
            top_floor  = FLOOR_W'(MAX_FLOORS_DEFAULT);
            car_floor  = '0;
            motion     = MOT_WAIT;
            active     = 1'b1;
            calls_up   = '0;
            calls_down = '0;
        endfunction

        function void set_top_floor(logic [FLOOR_W-1:0] value);
            top_floor = (value > MAX_FLOORS_DEFAULT) ? FLOOR_W'(MAX_FLOORS_DEFAULT) : value;
        endfunction

        // wait when nothing pending, keep heading while calls remain ahead,
        // otherwise turn around
        function void steer();
            if (!active)
                return;
            if (calls_up == '0 && calls_down == '0)
                motion = MOT_WAIT;
            else if (motion == MOT_WAIT)
                motion = (calls_up != '0) ? MOT_UP : MOT_DOWN;
            else if ((motion == MOT_UP) ? (calls_up == '0) : (calls_down == '0))
                motion = (motion == MOT_DOWN) ? MOT_UP : MOT_DOWN;
        endfunction

        function bit tick_car();
            bit served;
            int goal;
            int next_floor;
            served = 1'b0;
            goal   = 0;
            if (!active)
                return 1'b0;
            steer();
            if (motion == MOT_WAIT)
                return 1'b1;
            // nearest call ahead: lowest above when going up, highest below
            if (motion == MOT_UP)
            begin
                for (int i = 63; i >= 0; i--)
                    if (calls_up[i])
                        goal = i;
            end
            else
            begin
                for (int i = 0; i < 64; i++)
                    if (calls_down[i])
                        goal = i;
            end
            if (goal == int'(car_floor))
            begin
                if (motion == MOT_UP)
                    calls_up[goal] = 1'b0;
                else
                    calls_down[goal] = 1'b0;
                steer();
                served = 1'b1;
            end
            if (motion != MOT_WAIT)
            begin
                next_floor = int'(car_floor) + ((motion == MOT_UP) ? 1 : -1);
                if (next_floor > int'(top_floor))
                    next_floor = int'(top_floor);
                if (next_floor < 0)
                    next_floor = 0;
                car_floor = next_floor[FLOOR_W-1:0];
            end
            return served;
        endfunction

        // note an accepted word: update the state and queue its result
        function void take_item(logic [FUNC_W-1:0] func, logic [FLOOR_W-1:0] floor);
            ess_result_t word;
            int unsigned fare;
            word = '0;
            fare = 0;
            case (func)
                FN_TICK:
                begin
                    word.serviced = tick_car();
                    served_ticks += word.serviced;
                end
                FN_REQUEST, FN_COST:
                begin
                    if (floor > top_floor)
                    begin
                        word.rejected = 1'b1;
                        rejected_seen++;
                    end
                    else if (func == FN_REQUEST)
                    begin
                        if (floor > car_floor)
                            calls_up[floor] = 1'b1;
                        else if (floor < car_floor)
                            calls_down[floor] = 1'b1;
                    end
                    else
                    begin
                        if (floor > car_floor)
                            fare = int'(floor) - int'(car_floor) + $countones(calls_up);
                        else if (floor < car_floor)
                            fare = int'(car_floor) - int'(floor) + $countones(calls_down);
                        if (fare >= COST_MAX)
                        begin
                            fare = COST_MAX;
                            capped_costs++;
                        end
                        word.cost = fare[COST_W-1:0];
                    end
                end
                FN_ENABLE:
                begin
                    motion = MOT_WAIT;
                    active = 1'b1;
                end
                FN_DISABLE:
                begin
                    motion = MOT_OFF;
                    active = 1'b0;
                end
                default: ;
            endcase
            word.position = car_floor;
            word.status   = motion;
            due_results.push_back(word);
        endfunction

        function void match_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(ess_result_t got);
            ess_result_t want;
            if (due_results.size() == 0)
            begin
                $error("result word delivered with nothing expected");
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            checked++;
            match_field("serviced", want.serviced, got.serviced);
            match_field("position", want.position, got.position);
            match_field("status", want.status, got.status);
            match_field("cost", want.cost, got.cost);
            match_field("rejected", want.rejected, got.rejected);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    always #10 clk = ~clk;

    ess_in_if  item_ch ();
    ess_out_if res_ch ();
    ess_cfg_if cfg_ch ();

    elevator_scan_scheduler #(
        .MAX_FLOORS (MAX_FLOORS_DEFAULT)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    car_route_board board = new();

    int unsigned tx_max      = 10;  // sender idle ceiling per word
    int unsigned rx_max      = 10;  // receiver stall ceiling per word
    bit          long_hold   = 1'b0;
    int unsigned words_sent  = 0;
    int unsigned cfg_writes  = 0;
    int unsigned cycle_count = 0;

    // ------------------------------------------------------------------------
    // Watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned gap;
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = $urandom_range(0, rx_max);
            if (long_hold)
            begin
                // long stall so the output register fills and item.ready drops
                gap       = 150;
                long_hold = 1'b0;
            end
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // result monitor: values read at the edge are the pre-edge values
    always @(posedge clk)
        if (rst_n && res_ch.valid && res_ch.ready)
            board.check_result({res_ch.serviced, res_ch.position, res_ch.status,
                                res_ch.cost, res_ch.rejected});

    // ------------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------------

    // Offer one word after a random gap. valid is left high on acceptance so
    // back-to-back words never drop it within a step.
    task automatic send_word(logic [FUNC_W-1:0] func, logic [FLOOR_W-1:0] floor);
        int unsigned gap;
        gap = $urandom_range(0, tx_max);
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.func  <= func;
        item_ch.floor <= floor;
        do @(posedge clk); while (!(item_ch.valid && item_ch.ready));
        board.take_item(func, floor);
        words_sent++;
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_all_results();
        item_ch.valid <= 1'b0;
        while (board.due_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_top_floor(logic [FLOOR_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
        cfg_ch.valid <= 1'b0;
        board.set_top_floor(value);
        cfg_writes++;
    endtask

    // mostly floors that exist, now and then anything the field can carry
    function automatic logic [FLOOR_W-1:0] pick_floor();
        if ($urandom_range(0, 6) == 0)
            return FLOOR_W'($urandom_range(0, 63));
        return FLOOR_W'($urandom_range(0, board.top_floor));
    endfunction

    function automatic logic [FLOOR_W-1:0] any_floor();
        return FLOOR_W'($urandom_range(0, 63));
    endfunction

    // tick until no call is pending (bounded: calls above a lowered
    // num_floors can never be reached), with a few cost queries mixed in
    task automatic run_to_rest(int unsigned cap);
        int unsigned n;
        if (!board.active)
            send_word(FN_ENABLE, any_floor());
        for (n = 0; n < cap && (board.calls_up | board.calls_down) != '0; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                send_word(FN_COST, pick_floor());
            else
                send_word(FN_TICK, any_floor());
        end
    endtask

    function automatic int unsigned pick_ceiling();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 3;
            default: return 10;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned     phase;
        int unsigned     kind;
        int unsigned     pick;
        int unsigned     idx;
        logic [FLOOR_W-1:0] top;
        logic [FLOOR_W-1:0] stops[$];

        rst_n         <= 1'b0;
        item_ch.valid <= 1'b0;
        item_ch.func  <= FN_TICK;
        item_ch.floor <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: car at 0, num_floors at its reset value ----
        send_word(FN_COST, 0);            // query at the car floor: cost 0
        send_word(FN_TICK, 63);           // idle tick: waiting counts as serviced
        send_word(FN_REQUEST, 0);         // request at the car floor is dropped
        send_word(FN_REQUEST, 63);        // top floor
        send_word(FN_REQUEST, 3);
        send_word(FN_COST, 63);
        send_word(FN_COST, 1);
        repeat (4) send_word(FN_TICK, 0); // climb to 3, service it, keep going up
        send_word(FN_REQUEST, 1);         // lands in the below set
        send_word(FN_DISABLE, 0);
        send_word(FN_TICK, 0);            // frozen while disabled
        send_word(FN_REQUEST, 2);         // still recorded while disabled
        send_word(FN_COST, 0);
        send_word(FN_ENABLE, 0);
        for (int f = FN_DISABLE + 1; f < (1 << FUNC_W); f++)
            send_word(FUNC_W'(f), 63);    // unused codes: no operation

        // shrink the building below the car with calls still pending
        wait_all_results();
        write_top_floor(2);
        send_word(FN_REQUEST, 3);         // beyond num_floors: rejected
        send_word(FN_COST, 63);           // rejected as well
        send_word(FN_TICK, 0);            // car pulled down to num_floors
        send_word(FN_TICK, 0);            // clamped, call at 63 out of reach

        // ---- bring the car home and load every floor: cost hits its ceiling
        wait_all_results();
        write_top_floor(63);
        tx_max = 0;
        run_to_rest(200);
        send_word(FN_REQUEST, 0);
        run_to_rest(200);
        for (int f = 1; f <= 63; f++)
            stops.push_back(FLOOR_W'(f));
        while (stops.size() != 0)
        begin
            idx = $urandom_range(0, stops.size() - 1);
            send_word(FN_REQUEST, stops[idx]);
            stops.delete(idx);
        end
        send_word(FN_COST, 63);
        send_word(FN_COST, 0);
        tx_max = 10;
        run_to_rest(200);

        // ---- random phases: one num_floors setting per phase ----
        phase = 0;
        while (words_sent < ITEMS_TARGET)
        begin
            // usually let the car finish first; sometimes leave calls behind
            if ($urandom_range(0, 3) != 0)
                run_to_rest(160);
            wait_all_results();
            case (phase % 5)
                0:       top = 2;
                1:       top = 63;
                default: top = FLOOR_W'($urandom_range(2, 63));
            endcase
            write_top_floor(top);
            tx_max = pick_ceiling();
            rx_max = pick_ceiling();
            if (phase == 0)
            begin
                // sender keeps offering back to back during a long receiver stall
                tx_max    = 0;
                long_hold = 1'b1;
            end

            for (int blk = 0; blk < 6 && words_sent < ITEMS_TARGET; blk++)
            begin
                kind = $urandom_range(0, 9);
                case (kind)
                    6:  // noise: any code, any floor
                        repeat ($urandom_range(5, 15))
                            send_word(FUNC_W'($urandom_range(0, 7)), any_floor());
                    7:  // cost burst
                        repeat ($urandom_range(4, 10))
                            send_word(FN_COST, pick_floor());
                    8:  // disabled stretch
                    begin
                        send_word(FN_DISABLE, any_floor());
                        repeat ($urandom_range(3, 8))
                        begin
                            pick = $urandom_range(0, 2);
                            send_word(pick == 0 ? FN_TICK : (pick == 1 ? FN_REQUEST : FN_COST),
                                      pick_floor());
                        end
                        send_word(FN_ENABLE, any_floor());
                    end
                    9:  // bare ticks
                        repeat ($urandom_range(5, 20))
                            send_word(FN_TICK, any_floor());
                    default:
                    begin
                        // trip: a few calls while the car is moving, then run out
                        repeat ($urandom_range(1, 5))
                        begin
                            send_word(FN_REQUEST, pick_floor());
                            repeat ($urandom_range(0, 3))
                                send_word(FN_TICK, any_floor());
                        end
                        run_to_rest(150);
                    end
                endcase
            end
            phase++;
        end

        // ---- wrap up ----
        wait_all_results();
        repeat (5) @(posedge clk);
        $display("Run: %0d words over %0d num_floors settings, %0d results checked",
                 words_sent, cfg_writes, board.checked);
        $display("Run: %0d serviced ticks, %0d rejected floors, %0d costs at ceiling",
                 board.served_ticks, board.rejected_seen, board.capped_costs);
        if (board.mismatches == 0 && board.due_results.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
